### src/lsac_pkg.sv
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types and constants for the roof light switch and animation
// controller: frame pattern codes, register indexes and fixed timings.
// ----------------------------------------------------------------------------
package lsac_pkg;

    // Frame pattern codes
    typedef logic [2:0] t_pattern;
    localparam t_pattern PAT_NONE  = 3'd0;
    localparam t_pattern PAT_WHITE = 3'd1;
    localparam t_pattern PAT_FILL  = 3'd2;
    localparam t_pattern PAT_RED   = 3'd3;
    localparam t_pattern PAT_DARK  = 3'd4;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_WHITE_LEVEL   = 3'd0;
    localparam t_cfg_index CFG_DEBOUNCE_MS   = 3'd1;
    localparam t_cfg_index CFG_LONG_PRESS_MS = 3'd2;
    localparam t_cfg_index CFG_DOOR_ANIM_MS  = 3'd3;
    localparam t_cfg_index CFG_FLASH_COUNT   = 3'd4;
    localparam t_cfg_index CFG_MODE_COUNT    = 3'd5;

    localparam int CFG_DATA_W = 16;

    // Fixed timings in ms
    localparam logic [31:0] CLICK_WINDOW_MS = 32'd500;
    localparam logic [16:0] FLASH_PERIOD_MS = 17'd500;
    localparam logic [15:0] FLASH_HALF_MS   = 16'd250;

    // elapsed / 250 = (elapsed >> 1) / 125; ceil(2^23 / 125), exact below 2^16
    localparam logic [16:0] FLASH_HALF_RECIP = 17'd67109;
    localparam int          FLASH_HALF_SHIFT = 23;

    localparam logic [7:0] RED_LEVEL = 8'd255;
    localparam logic [6:0] LIT_MAX   = 7'd127;

endpackage

### src/light_switch_and_animation_controller.sv
// ----------------------------------------------------------------------------
// light_switch_and_animation_controller
// Roof light controller: debounced switch clicks select a mode, door and
// error animations draw the roof frame. One item is one control-loop pass.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes ST_SWITCH, then ST_DOOR_CHK and ST_DOOR_DIV
//   (the divider) while a door fill runs (DIV_W = 16 +
//   clog2(STRIP_LEDS+1), 23 for 64 LEDs), ST_ERR_CHK while an error flash runs,
//   then ST_TRIGGER and ST_LOAD. Throughput: one item at a time; the next item
//   is taken once the result is in the output register, which holds it while
//   stalled. Reset: synchronous, active low; state cleared, registers return
//   to default values, frame shows nothing drawn.
module light_switch_and_animation_controller #(
    parameter int STRIP_LEDS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  lsac_pkg::t_cfg_index           i_cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_switch_down,
    input  logic                           i_door_open,
    input  logic                           i_error_request,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_pattern,
    output logic [7:0]                     o_level,
    output logic [6:0]                     o_lit_count,
    output logic [7:0]                     o_mode,
    output logic [7:0]                     o_clicks,
    output logic                           o_door_running,
    output logic                           o_error_running
);
    import lsac_pkg::*;

    // Dividend holds elapsed (< 2^16) times STRIP_LEDS for the fill position.
    localparam int DIV_W = 16 + $clog2(STRIP_LEDS + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SWITCH   = 4'd1;
    localparam logic [3:0] ST_DOOR_CHK = 4'd2;
    localparam logic [3:0] ST_DOOR_DIV = 4'd3;
    localparam logic [3:0] ST_ERR_CHK  = 4'd4;
    localparam logic [3:0] ST_TRIGGER  = 4'd6;
    localparam logic [3:0] ST_LOAD     = 4'd7;

    logic [3:0] r_state, n_state;

    // configuration registers
    logic [7:0]  r_white_level;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_long_press_ms;
    logic [15:0] r_door_anim_ms;
    logic [7:0]  r_flash_count;
    logic [7:0]  r_mode_count;

    // captured item
    logic [31:0] r_now;
    logic        r_sw;
    logic        r_door_req;
    logic        r_err_req;

    // controller state
    logic        r_prev_switch,   n_prev_switch;
    logic        r_press_held,    n_press_held;
    logic [31:0] r_press_start,   n_press_start;
    logic [31:0] r_last_click,    n_last_click;
    logic [31:0] r_last_edge,     n_last_edge;
    logic [7:0]  r_click_total,   n_click_total;
    logic [7:0]  r_mode_reg,      n_mode_reg;
    logic        r_door_active,   n_door_active;
    logic        r_error_active,  n_error_active;
    logic [31:0] r_anim_start,    n_anim_start;
    logic [31:0] r_elapsed,       n_elapsed;
    t_pattern    r_frame_kind,    n_frame_kind;
    logic [7:0]  r_frame_level,   n_frame_level;
    logic [6:0]  r_frame_lit,     n_frame_lit;

    // output register
    logic        r_out_valid,     n_out_valid;
    t_pattern    r_o_pattern;
    logic [7:0]  r_o_level;
    logic [6:0]  r_o_lit;
    logic [7:0]  r_o_mode;
    logic [7:0]  r_o_clicks;
    logic        r_o_door;
    logic        r_o_error;

    // divider for the fill position
    logic              w_div_start;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_div_dividend;
    logic [DIV_W-1:0]  w_div_quo;

    // flash phase helpers
    logic        w_err_run;
    logic [32:0] w_half_prod;

    // switch stage helpers
    logic [31:0] w_since_edge;
    logic [31:0] w_press_dur;
    logic [31:0] w_since_click;
    logic [7:0]  w_click_next;
    logic [16:0] w_flash_limit;
    logic        w_accept;
    logic        w_load;

    assign w_accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall    = (r_state != ST_IDLE);
    assign w_load        = (r_state == ST_LOAD) && (!r_out_valid || !i_out_stall);

    assign w_since_edge  = r_now - r_last_edge;
    assign w_press_dur   = r_now - r_press_start;
    assign w_since_click = r_now - r_last_click;
    assign w_click_next  = (w_since_click < CLICK_WINDOW_MS) ? r_click_total + 8'd1 : 8'd1;
    assign w_flash_limit = 17'(r_flash_count) * FLASH_PERIOD_MS;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_level   <= 8'd255;
            r_debounce_ms   <= 16'd50;
            r_long_press_ms <= 16'd1000;
            r_door_anim_ms  <= 16'd2000;
            r_flash_count   <= 8'd5;
            r_mode_count    <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHITE_LEVEL:   r_white_level   <= i_cfg_data[7:0];
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                CFG_DOOR_ANIM_MS:  r_door_anim_ms  <= i_cfg_data;
                CFG_FLASH_COUNT:   r_flash_count   <= i_cfg_data[7:0];
                CFG_MODE_COUNT:    r_mode_count    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now      <= i_now_ms;
            r_sw       <= i_switch_down;
            r_door_req <= i_door_open;
            r_err_req  <= i_error_request;
        end
    end

    // ------------------------------------------------------------------
    // Fill position goes through the divider; the quarter-second slot of
    // the flash is a reciprocal multiply, bit 0 of the quotient picks red.
    // ------------------------------------------------------------------
    assign w_div_start    = (r_state == ST_DOOR_CHK) && (r_elapsed < {16'd0, r_door_anim_ms});
    assign w_div_dividend = DIV_W'(r_elapsed[15:0]) * DIV_W'(STRIP_LEDS);
    assign w_err_run      = (r_elapsed < {15'd0, w_flash_limit});
    assign w_half_prod    = 33'(r_elapsed[16:1]) * 33'(FLASH_HALF_RECIP);

    lsac_div #(
        .DW(DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_door_anim_ms),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_prev_switch  = r_prev_switch;
        n_press_held   = r_press_held;
        n_press_start  = r_press_start;
        n_last_click   = r_last_click;
        n_last_edge    = r_last_edge;
        n_click_total  = r_click_total;
        n_mode_reg     = r_mode_reg;
        n_door_active  = r_door_active;
        n_error_active = r_error_active;
        n_anim_start   = r_anim_start;
        n_elapsed      = r_elapsed;
        n_frame_kind   = r_frame_kind;
        n_frame_level  = r_frame_level;
        n_frame_lit    = r_frame_lit;
        n_out_valid    = r_out_valid && i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWITCH;
                end
            end

            ST_SWITCH: begin
                // sampled only once the debounce time has gone by
                if (w_since_edge >= {16'd0, r_debounce_ms}) begin
                    if (r_sw && !r_prev_switch) begin
                        n_press_held  = 1'b1;
                        n_press_start = r_now;
                        n_last_edge   = r_now;
                    end else if (!r_sw && r_prev_switch) begin
                        if (r_press_held) begin
                            // short release counts a click; long release does not
                            if (w_press_dur < {16'd0, r_long_press_ms}) begin
                                n_click_total = w_click_next;
                                n_last_click  = r_now;
                                if (w_click_next != 8'd0 && w_click_next <= r_mode_count) begin
                                    n_mode_reg    = w_click_next - 8'd1;
                                    n_frame_kind  = PAT_WHITE;
                                    n_frame_level = r_white_level;
                                    n_frame_lit   = 7'd0;
                                end
                            end
                            n_press_held = 1'b0;
                        end
                        n_last_edge = r_now;
                    end
                    n_prev_switch = r_sw;
                end
                n_elapsed = r_now - r_anim_start;
                if (r_door_active) begin
                    n_state = ST_DOOR_CHK;
                end else if (r_error_active) begin
                    n_state = ST_ERR_CHK;
                end else begin
                    n_state = ST_TRIGGER;
                end
            end

            ST_DOOR_CHK: begin
                if (w_div_start) begin
                    n_state = ST_DOOR_DIV;
                end else begin
                    n_door_active = 1'b0;
                    n_frame_kind  = PAT_WHITE;
                    n_frame_level = r_white_level;
                    n_frame_lit   = 7'd0;
                    n_state       = r_error_active ? ST_ERR_CHK : ST_TRIGGER;
                end
            end

            ST_DOOR_DIV: begin
                if (w_div_done) begin
                    n_frame_kind  = PAT_FILL;
                    n_frame_level = {2'b00, r_white_level[7:2]};
                    n_frame_lit   = (w_div_quo >= DIV_W'(LIT_MAX)) ? LIT_MAX
                                  : w_div_quo[6:0] + 7'd1;
                    n_state       = r_error_active ? ST_ERR_CHK : ST_TRIGGER;
                end
            end

            ST_ERR_CHK: begin
                if (w_err_run) begin
                    // even quarter-second slots are red, odd ones dark
                    n_frame_kind  = w_half_prod[FLASH_HALF_SHIFT] ? PAT_DARK : PAT_RED;
                    n_frame_level = w_half_prod[FLASH_HALF_SHIFT] ? 8'd0 : RED_LEVEL;
                    n_frame_lit   = 7'd0;
                end else begin
                    n_error_active = 1'b0;
                    n_frame_kind   = PAT_WHITE;
                    n_frame_level  = r_white_level;
                    n_frame_lit    = 7'd0;
                end
                n_state = ST_TRIGGER;
            end

            ST_TRIGGER: begin
                if (r_door_req && !r_door_active && !r_error_active) begin
                    n_door_active = 1'b1;
                    n_anim_start  = r_now;
                end
                if (r_err_req) begin
                    n_error_active = 1'b1;
                    n_anim_start   = r_now;
                end
                n_state = ST_LOAD;
            end

            ST_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_prev_switch  <= 1'b0;
            r_press_held   <= 1'b0;
            r_press_start  <= '0;
            r_last_click   <= '0;
            r_last_edge    <= '0;
            r_click_total  <= '0;
            r_mode_reg     <= '0;
            r_door_active  <= 1'b0;
            r_error_active <= 1'b0;
            r_anim_start   <= '0;
            r_frame_kind   <= PAT_NONE;
            r_frame_level  <= '0;
            r_frame_lit    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_prev_switch  <= n_prev_switch;
            r_press_held   <= n_press_held;
            r_press_start  <= n_press_start;
            r_last_click   <= n_last_click;
            r_last_edge    <= n_last_edge;
            r_click_total  <= n_click_total;
            r_mode_reg     <= n_mode_reg;
            r_door_active  <= n_door_active;
            r_error_active <= n_error_active;
            r_anim_start   <= n_anim_start;
            r_frame_kind   <= n_frame_kind;
            r_frame_level  <= n_frame_level;
            r_frame_lit    <= n_frame_lit;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
    end

    // output register, loaded only when empty or being taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_pattern <= r_frame_kind;
            r_o_level   <= r_frame_level;
            r_o_lit     <= r_frame_lit;
            r_o_mode    <= r_mode_reg;
            r_o_clicks  <= r_click_total;
            r_o_door    <= r_door_active;
            r_o_error   <= r_error_active;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pattern       = r_o_pattern;
    assign o_level         = r_o_level;
    assign o_lit_count     = r_o_lit;
    assign o_mode          = r_o_mode;
    assign o_clicks        = r_o_clicks;
    assign o_door_running  = r_o_door;
    assign o_error_running = r_o_error;

endmodule

### src/lsac_div.sv
// ----------------------------------------------------------------------------
// lsac_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module lsac_div #(
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    import lsac_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [15:0]   r_rem;
    logic [DW-1:0] r_quo;

    logic [16:0] w_trial;
    logic        w_fits;
    logic [16:0] w_diff;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_done <= (r_cnt == CW'(1));
            r_busy <= (r_cnt != CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[15:0] : w_trial[15:0];
            r_quo <= {r_quo[DW-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/lsac_checker.sv
// ----------------------------------------------------------------------------
// lsac_checker
// Port-level checks on the roof light controller, bound to the top level.
// ----------------------------------------------------------------------------
module lsac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_pattern,
    input logic [7:0] o_level,
    input logic [6:0] o_lit_count
);
    import lsac_pkg::*;

    // one item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // only the fill pattern lights a partial strip
    a_lit_only_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pattern != PAT_FILL) |-> (o_lit_count == 7'd0))
        else $error("lit count set outside door fill");

    // dark and empty frames carry no level
    a_dark_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pattern == PAT_NONE || o_pattern == PAT_DARK))
        |-> (o_level == 8'd0))
        else $error("level set on a dark frame");

    // the fill always lights at least one pixel
    a_fill_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pattern == PAT_FILL) |-> (o_lit_count != 7'd0))
        else $error("door fill with no pixel lit");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pattern)
            && $stable(o_level) && $stable(o_lit_count)))
        else $error("stalled result changed");

endmodule

bind light_switch_and_animation_controller lsac_checker u_lsac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pattern   (o_pattern),
    .o_level     (o_level),
    .o_lit_count (o_lit_count)
);
